### rtl/core/mrp_pkg.sv
// Miller-Rabin package: sequencer state type and witness base table.
// No dependencies.
`default_nettype none
package mrp_pkg;
    typedef enum logic [3:0] {
        ST_IDLE, ST_SMALL, ST_DIV, ST_SETUP, ST_MUL, ST_POWNEXT,
        ST_CHECK, ST_SQR, ST_NEXTB, ST_DONE
    } state_t;
    localparam int BASE_COUNT  = 12;
    localparam int SMALL_LIMIT = 40;
    function automatic logic [5:0] base_of(input logic [3:0] k);
        unique case (k)
            4'd0:  base_of = 6'd2;
            4'd1:  base_of = 6'd3;
            4'd2:  base_of = 6'd5;
            4'd3:  base_of = 6'd7;
            4'd4:  base_of = 6'd11;
            4'd5:  base_of = 6'd13;
            4'd6:  base_of = 6'd17;
            4'd7:  base_of = 6'd19;
            4'd8:  base_of = 6'd23;
            4'd9:  base_of = 6'd29;
            4'd10: base_of = 6'd31;
            4'd11: base_of = 6'd37;
            default: base_of = 6'd2;
        endcase
    endfunction
endpackage
`default_nettype wire

### rtl/core/mrp_modmul.sv
// Bit-serial modular multiplier: (x*y) mod m, one bit of y per cycle, MSB first.
// Depends on nothing; used by miller_rabin_primality.
`default_nettype none
module mrp_modmul #(
    parameter int W = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] x,
    input  wire logic [W-1:0] y,
    input  wire logic [W-1:0] m,
    output logic              done,
    output logic [W-1:0]      p
);
    localparam int CW = $clog2(W+1);
    logic [W-1:0]  acc_reg, acc_next, y_reg, y_next, x_reg, m_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next;
    logic [W:0]    dbl, t1, add;
    logic [W-1:0]  t1r;
    logic [W+1:0]  t2;

    // acc <- (2*acc + bit*x) mod m, each step two compare-and-subtracts
    always_comb begin
        dbl = {acc_reg, 1'b0};
        t1 = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        t1r = t1[W-1:0];
        add = y_reg[W-1] ? {1'b0, x_reg} : '0;
        t2 = {2'b0, t1r} + {1'b0, add};
        if (t2 >= {2'b0, m_reg}) t2 = t2 - {2'b0, m_reg};
    end

    always_comb begin
        acc_next = acc_reg; y_next = y_reg; cnt_next = cnt_reg;
        busy_next = busy_reg; done_next = 1'b0;
        if (start) begin
            acc_next = '0; y_next = y; cnt_next = CW'(W); busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = t2[W-1:0];
            y_next = {y_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0; done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next; cnt_reg <= cnt_next;
        end
        acc_reg <= acc_next; y_reg <= y_next;
        if (start) begin
            x_reg <= x; m_reg <= m;
        end
    end
    assign done = done_reg;
    assign p = acc_reg;
endmodule
`default_nettype wire

### rtl/core/miller_rabin_primality.sv
// Deterministic Miller-Rabin primality test, top level and sequencer.
// Depends on mrp_pkg and mrp_modmul.
//
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | candidate [NUM_WIDTH-1:0], zero padded to bytes
// m_axis  | out | is_prime [0], padded to 8 bits
//
// One candidate in flight. Each modular product is one pass of the bit-serial
// multiplier plus one sequencer step; a candidate needs at most about
// 12 * 2*NUM_WIDTH products. Values up to 40 finish straight after the
// small-value check, multiples of a base right after that base's remainder
// pass. Divisibility by a base is a bit-serial remainder, one bit per step.
// The result waits in an output register; s_tready rises again once it is
// taken. Reset is synchronous, active low.
`default_nettype none
module miller_rabin_primality #(
    parameter int NUM_WIDTH = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [((NUM_WIDTH+7)/8)*8-1:0] s_tdata, // candidate
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata                     // is_prime
);
    import mrp_pkg::*;
    localparam int W  = NUM_WIDTH;
    localparam int CW = $clog2(W+1);

    state_t        st_reg, st_next;
    logic [W-1:0]  n_reg, d_reg, d_next, e_reg, e_next;
    logic [W-1:0]  acc_reg, acc_next, sq_reg, sq_next;
    logic [CW-1:0] s_reg, s_next, i_reg, i_next;
    logic [3:0]    k_reg, k_next;
    logic [5:0]    rem_reg, rem_next;
    logic          ph_reg, ph_next; // 0: acc*=sq, 1: sq*=sq
    logic          res_reg, res_next, ov_reg, ov_next;
    logic          mstart, mdone;
    logic [W-1:0]  mx, my, mp, nm1;
    logic [6:0]    r2;
    logic [5:0]    base;

    mrp_modmul #(.W(W)) u_mul (
        .aclk, .aresetn, .start(mstart), .x(mx), .y(my), .m(n_reg),
        .done(mdone), .p(mp)
    );

    assign base = base_of(k_reg);
    assign nm1  = n_reg - 1'b1;
    assign r2   = {rem_reg, e_reg[W-1]};

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:    if (s_tvalid) st_next = ST_SMALL;
            ST_SMALL:   st_next = (n_reg <= W'(SMALL_LIMIT)) ? ST_DONE : ST_DIV;
            ST_DIV:     if (i_reg == CW'(1)) st_next = ST_SETUP;
            ST_SETUP:   st_next = (rem_reg == '0) ? ST_DONE : ST_MUL;
            ST_MUL:     if (mdone) st_next = ST_POWNEXT;
            ST_POWNEXT: st_next = (ph_reg && (e_reg >> 1) == '0) ? ST_CHECK : ST_MUL;
            // 1 only passes before any squaring; n-1 passes at any point
            ST_CHECK:   st_next = (acc_reg == nm1 || (acc_reg == W'(1) && i_reg == CW'(1)))
                                ? ST_NEXTB
                                : (i_reg >= s_reg) ? ST_DONE : ST_SQR;
            ST_SQR:     if (mdone) st_next = ST_CHECK;
            ST_NEXTB:   st_next = (k_reg == 4'(BASE_COUNT-1)) ? ST_DONE : ST_DIV;
            ST_DONE:    if (m_tready) st_next = ST_IDLE;
            default:    st_next = ST_IDLE;
        endcase
    end

    always_comb begin
        d_next = d_reg; e_next = e_reg; acc_next = acc_reg; sq_next = sq_reg;
        s_next = s_reg; i_next = i_reg; k_next = k_reg; rem_next = rem_reg;
        ph_next = ph_reg; res_next = res_reg; ov_next = ov_reg;
        mstart = 1'b0; mx = acc_reg; my = sq_reg;
        unique case (st_reg)
            ST_IDLE: begin
                k_next = '0; ov_next = 1'b0;
            end
            ST_SMALL: begin
                res_next = 1'b0;
                for (int j = 0; j < BASE_COUNT; j++)
                    if (n_reg == W'(base_of(4'(j)))) res_next = 1'b1;
                // n-1 = d*2^s, strip low zeros one per cycle in ST_DIV
                d_next = nm1; s_next = '0;
                e_next = n_reg; rem_next = '0; i_next = CW'(W);
            end
            ST_DIV: begin
                // remainder n mod base, one bit per cycle; also strip d zeros
                rem_next = (r2 >= {1'b0, base}) ? 6'(r2 - {1'b0, base}) : r2[5:0];
                e_next = {e_reg[W-2:0], 1'b0};
                i_next = i_reg - 1'b1;
                if (k_reg == '0 && !d_reg[0] && d_reg != '0) begin
                    d_next = d_reg >> 1; s_next = s_reg + 1'b1;
                end
            end
            ST_SETUP: begin
                if (k_reg == '0 && !d_reg[0] && d_reg != '0) begin
                    d_next = d_reg >> 1; s_next = s_reg + 1'b1;
                end else begin
                    i_next = '0;
                    if (rem_reg == '0) res_next = 1'b0;
                    else begin
                        acc_next = W'(1); sq_next = W'(base); e_next = d_reg;
                        ph_next = 1'b0; mstart = 1'b1;
                        mx = W'(1); my = W'(base); // first product acc*sq, acc = 1
                    end
                end
            end
            ST_MUL: if (mdone) begin
                if (ph_reg) sq_next = mp;
                else if (e_reg[0]) acc_next = mp;
            end
            ST_POWNEXT: begin
                if (ph_reg) e_next = e_reg >> 1;
                ph_next = ~ph_reg;
                if (!(ph_reg && (e_reg >> 1) == '0)) begin
                    mstart = 1'b1;
                    mx = ph_reg ? acc_reg : sq_reg; my = sq_reg;
                end
                if (ph_reg && (e_reg >> 1) == '0) begin
                    e_next = '0; i_next = CW'(1);
                end
            end
            ST_CHECK: begin
                if (acc_reg == nm1 || (acc_reg == W'(1) && i_reg == CW'(1))) begin
                    res_next = 1'b1;
                end else if (i_reg >= s_reg) begin
                    res_next = 1'b0;
                end else begin
                    mstart = 1'b1; mx = acc_reg; my = acc_reg;
                end
            end
            ST_SQR: if (mdone) begin
                acc_next = mp; i_next = i_reg + 1'b1;
            end
            ST_NEXTB: begin
                k_next = k_reg + 1'b1; e_next = n_reg; rem_next = '0; i_next = CW'(W);
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= ST_IDLE;
        else st_reg <= st_next;
        if (st_reg == ST_IDLE && s_tvalid) n_reg <= s_tdata[W-1:0];
        d_reg <= d_next; e_reg <= e_next; acc_reg <= acc_next; sq_reg <= sq_next;
        s_reg <= s_next; i_reg <= i_next; k_reg <= k_next; rem_reg <= rem_next;
        ph_reg <= ph_next; res_reg <= res_next; ov_reg <= ov_next;
    end

    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = (st_reg == ST_DONE);
    assign m_tdata  = {7'd0, res_reg & ~ov_reg};

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("in and out both open");
    a_done_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    a_small_one: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_SMALL && n_reg < W'(2) |=> !res_reg)
        else $error("zero or one marked prime");
endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for miller_rabin_primality: drives candidates over the
// input stream, predicts primality and compares every result transfer.
// Depends on the RTL top level miller_rabin_primality only.
`timescale 1ns / 1ps

module testbench;
    localparam int W = 32;
    localparam int STALL_LONG = 200000;   // long receiver hold-off, in cycles
    localparam int WATCHDOG_LIMIT = 1000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;            // candidate [31:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;                 // is_prime [0], padding [7:1]

    miller_rabin_primality #(.NUM_WIDTH(W)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Candidates waiting to be sent, and verdicts waiting to arrive.
    logic [31:0] candidate_q[$];
    logic [31:0] sent_q[$];
    bit          verdict_q[$];
    int          mismatches = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_primes = 0;
    bit          stim_done = 1'b0;
    bit          long_hold = 1'b0;   // receiver hold-off request
    bit          drain_req = 1'b0;   // sender waits for empty scoreboard

    initial forever #1 aclk = ~aclk;

    // --- primality predictor, 64-bit arithmetic ---
    function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y,
                                           logic [63:0] m);
        return (x * y) % m;
    endfunction

    function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e,
                                           logic [63:0] m);
        logic [63:0] acc;
        logic [63:0] sq;
        acc = 1 % m;
        sq = b % m;
        while (e != 0) begin
            if (e[0]) acc = mulmod(acc, sq, m);
            sq = mulmod(sq, sq, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic bit strong_witness_ok(logic [63:0] n, logic [63:0] a);
        logic [63:0] d;
        logic [63:0] p;
        int s;
        if (n % a == 0) return 1'b0;
        d = n - 1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        p = powmod(a, d, n);
        if (p == 1 || p == n - 1) return 1'b1;
        for (int i = 1; i < s; i++) begin
            p = mulmod(p, p, n);
            if (p == n - 1) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit predict_prime(logic [31:0] cand);
        int unsigned bases[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
        logic [63:0] n;
        n = {32'd0, cand};
        if (n <= 40) begin
            foreach (bases[k]) if (n == bases[k]) return 1'b1;
            return 1'b0;
        end
        foreach (bases[k]) if (!strong_witness_ok(n, bases[k])) return 1'b0;
        return 1'b1;
    endfunction

    // Random value, mostly odd, often nudged up toward the next prime for deep runs.
    function automatic logic [31:0] rand_candidate();
        logic [31:0] v;
        int sel;
        sel = $urandom_range(0, 9);
        v = $urandom();
        if (sel < 2) v = $urandom_range(0, 200);
        else if (sel < 3) v = v | 32'h8000_0000;
        v[0] = (sel == 9) ? v[0] : 1'b1;
        if (sel >= 4 && sel < 8)
            for (int t = 0; t < 40 && !predict_prime(v); t++) v = v + 2;
        return v;
    endfunction

    // --- stimulus ---
    initial begin
        logic [31:0] directed[$];
        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd37, 32'd38, 32'd40,
                     32'd41, 32'd42, 32'd43, 32'd1369, 32'd2047, 32'd3215031751,
                     32'd2152302898, 32'd4294967291, 32'd4294967295,
                     32'd4294967294, 32'd2147483647, 32'hAAAA_AAAB,
                     32'h5555_5555, 32'd65537, 32'd25326001};
        foreach (directed[i]) candidate_q.push_back(directed[i]);
        for (int i = 0; i < 77; i++) candidate_q.push_back(rand_candidate());
    end

    // --- reset and flow control phases ---
    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk) aresetn = 1'b1;
        wait (n_sent >= 30);
        drain_req = 1'b1;
        wait (verdict_q.size() == 0 && !s_tvalid);
        @(negedge aclk) drain_req = 1'b0;
        wait (n_sent >= 50);
        long_hold = 1'b1;
        repeat (STALL_LONG / 1000) repeat (1000) @(posedge aclk);
        @(negedge aclk) long_hold = 1'b0;
    end

    // Acceptance seen at the last rising edge.
    bit s_tready_q = 1'b0;

    // --- driver: bursts with random gaps ---
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !s_tready_q) begin
                // hold the offered candidate until it is taken
            end else if (drain_req || candidate_q.size() == 0) begin
                s_tvalid <= 1'b0;
                if (candidate_q.size() == 0) stim_done <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else begin
                s_tdata <= candidate_q.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left <= 0) begin
                    burst_left <= $urandom_range(1, 6);
                    gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    int unsigned cyc = 0;
    always @(negedge aclk) begin
        if (aresetn) m_tready <= !long_hold && (($urandom_range(0, 3) != 0) || cyc[9]);
    end

    // --- monitor and checker ---
    int idle_cycles = 0;
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        s_tready_q <= s_tvalid && s_tready;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (s_tvalid && s_tready) begin
                sent_q.push_back(s_tdata);
                verdict_q.push_back(predict_prime(s_tdata));
                n_sent <= n_sent + 1;
            end
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected result transfer %0d", m_tdata);
                end else begin
                    logic [31:0] c;
                    bit exp_v;
                    c = sent_q.pop_front();
                    exp_v = verdict_q.pop_front();
                    n_checked <= n_checked + 1;
                    if (exp_v) n_primes <= n_primes + 1;
                    if (m_tdata[0] !== exp_v) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("candidate %0d: is_prime expected %0d got %0d",
                                     c, exp_v, m_tdata[0]);
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("miller_rabin_primality: mismatch");
                $finish;
            end
        end
    end

    // --- end of run ---
    initial begin
        wait (stim_done && !s_tvalid && verdict_q.size() == 0 && !long_hold);
        repeat (100) @(posedge aclk);
        $display("checked %0d candidates, %0d of them prime", n_checked, n_primes);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("miller_rabin_primality: match");
        end else begin
            $display("miller_rabin_primality: mismatch");
        end
        $finish;
    end
endmodule
